// File: rtl/fvnh_pkg.sv
// ----------------------------------------------------------------------------
// fvnh_pkg
// Shared widths, hash constants, register codes and pipeline side-band type
// for the fractal value noise height generator.
// ----------------------------------------------------------------------------
`default_nettype none

package fvnh_pkg;

   // field widths
   localparam int CELL_W     = 10;
   localparam int HEIGHT_W   = 16;
   localparam int FRAC_W     = 16;
   localparam int HASH_W     = 32;
   localparam int SEED_W     = 32;
   localparam int OCT_W      = 4;
   localparam int FREQ_W     = 16;
   localparam int RES_W      = 11;

   // register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_SEED       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OCTAVES    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FREQUENCY  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RESOLUTION = 2'd3;

   localparam logic [SEED_W-1:0] RESET_SEED       = 32'd0;
   localparam logic [OCT_W-1:0]  RESET_OCTAVES    = 4'd1;
   localparam logic [FREQ_W-1:0] RESET_FREQUENCY  = 16'd256;
   localparam logic [RES_W-1:0]  RESET_RESOLUTION = 11'd256;

   // lattice hash
   localparam logic [HASH_W-1:0] HASH_MUL_X    = 32'd374761393;
   localparam logic [HASH_W-1:0] HASH_MUL_Z    = 32'd668265263;
   localparam logic [HASH_W-1:0] HASH_MUL_SEED = 32'd2147483647;
   localparam logic [HASH_W-1:0] HASH_MUL_MIX  = 32'd1274126177;
   localparam logic [HASH_W-1:0] SEED_STEP     = 32'd101;

   // smoothstep and blend constants (unsigned, 16 fractional bits: Q2.16 and Q1.16)
   localparam logic [17:0] SMOOTH_THREE = 18'd196608;
   localparam logic [16:0] ONE_Q16      = 17'd65536;

   // side-band carried alongside the noise datapath
   typedef struct packed {
      logic                outside;
      logic                edge_full;
      logic [FRAC_W-1:0]   edge_gain;
   } side_type;

endpackage

`default_nettype wire

// File: rtl/fvnh_if.sv
// ----------------------------------------------------------------------------
// fvnh_if
// Valid/ready channels: grid cell requests in, height responses out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fvnh_req_if;
   logic                        valid;
   logic                        ready;
   logic [fvnh_pkg::CELL_W-1:0] cell_x;
   logic [fvnh_pkg::CELL_W-1:0] cell_z;

   modport source (output valid, output cell_x, output cell_z, input ready);
   modport sink   (input valid, input cell_x, input cell_z, output ready);
endinterface

interface fvnh_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fvnh_pkg::HEIGHT_W-1:0] height;

   modport source (output valid, output height, input ready);
   modport sink   (input valid, input height, output ready);
endinterface

`default_nettype wire

// File: rtl/fvnh_div_pipe.sv
// ----------------------------------------------------------------------------
// fvnh_div_pipe
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor, with a side-band vector travelling alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module fvnh_div_pipe #(
   parameter int LANES  = 1,
   parameter int NUM_W  = 8,
   parameter int DEN_W  = 4,
   parameter int SIDE_W = 1
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire logic                             in_valid,
   input  wire logic [LANES-1:0][NUM_W-1:0]      num,
   input  wire logic [DEN_W-1:0]                 den,
   input  wire logic [SIDE_W-1:0]                side_in,
   output logic                                  out_valid,
   output logic [LANES-1:0][NUM_W-1:0]           quo,
   output logic [SIDE_W-1:0]                     side_out
);

   localparam int STEPS = NUM_W;

   logic [STEPS-1:0]                 valid_ff;
   logic [LANES-1:0][DEN_W-1:0]      rem_ff  [STEPS];
   logic [LANES-1:0][NUM_W-1:0]      work_ff [STEPS];
   logic [SIDE_W-1:0]                side_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic                            src_valid;
      logic [LANES-1:0][DEN_W-1:0]     src_rem;
      logic [LANES-1:0][NUM_W-1:0]     src_work;
      logic [SIDE_W-1:0]               src_side;
      logic [LANES-1:0][DEN_W-1:0]     rem_in;
      logic [LANES-1:0][NUM_W-1:0]     work_in;

      if (i == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = '0;
         assign src_work  = num;
         assign src_side  = side_in;
      end else begin : g_next
         assign src_valid = valid_ff[i-1];
         assign src_rem   = rem_ff[i-1];
         assign src_work  = work_ff[i-1];
         assign src_side  = side_ff[i-1];
      end

      // bring down the next dividend bit and try the subtraction
      always_comb begin
         logic [DEN_W:0] trial;
         logic           fits;
         for (int l = 0; l < LANES; l++) begin
            trial = {src_rem[l], src_work[l][NUM_W-1]};
            fits  = (trial >= {1'b0, den});
            if (fits) begin
               rem_in[l] = DEN_W'(trial - {1'b0, den});
            end else begin
               rem_in[l] = trial[DEN_W-1:0];
            end
            work_in[l] = {src_work[l][NUM_W-2:0], fits};
         end
      end

      // advance the stage
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i]  <= rem_in;
            work_ff[i] <= work_in;
            side_ff[i] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign quo       = work_ff[STEPS-1];
   assign side_out  = side_ff[STEPS-1];

endmodule

`default_nettype wire

// File: rtl/fractal_value_noise_height.sv
// ----------------------------------------------------------------------------
// fractal_value_noise_height
// Heightmap generator: fractal value noise with a border falloff per cell.
//
// One grid cell (cell_x, cell_z) is taken per transaction and one height
// (unsigned Q0.16) comes back per cell, in order. The block accepts a new
// cell every clock cycle while the response side keeps up. The pipeline is
// 2*MAX_OCTAVES + 58 register stages deep: one input stage,
// (10+16+2+MAX_OCTAVES+7) + (16+MAX_OCTAVES) stages in the two bit-per-stage
// restoring dividers (sample position by grid size, and octave sum by total
// amplitude), four octave stages, the sum stage and the response register.
// A stalled response freezes the whole pipeline. The user must write the
// registers through the APB-style port only while no cell is in flight;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module fractal_value_noise_height #(
   parameter int MAX_OCTAVES    = 8,
   parameter int MAX_RESOLUTION = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   fvnh_req_if.sink                                  req_ch,
   fvnh_rsp_if.source                                rsp_ch,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [fvnh_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [fvnh_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [fvnh_pkg::CSR_DATA_W-1:0]           prdata,
   output logic                                      pready
);

   localparam int NW = $clog2(MAX_RESOLUTION + 1);
   localparam int KW = $clog2(MAX_OCTAVES + 1);
   localparam int MW = ((fvnh_pkg::CELL_W > NW) ? fvnh_pkg::CELL_W : NW) + 1;
   localparam int AW = fvnh_pkg::CELL_W + fvnh_pkg::FREQ_W + 2;
   localparam int DW = AW + MAX_OCTAVES + 7;
   localparam int WW = DW + fvnh_pkg::HASH_W;
   localparam int SW = fvnh_pkg::HEIGHT_W + MAX_OCTAVES;
   localparam int FW = fvnh_pkg::FRAC_W;
   localparam int HW = fvnh_pkg::HASH_W;
   localparam int SIDE_W = $bits(fvnh_pkg::side_type);

   // -------------------------------------------------------------------------
   // configuration registers
   // -------------------------------------------------------------------------
   logic [fvnh_pkg::SEED_W-1:0] seed_ff;
   logic [fvnh_pkg::OCT_W-1:0]  octaves_ff;
   logic [fvnh_pkg::FREQ_W-1:0] freq_ff;
   logic [fvnh_pkg::RES_W-1:0]  res_ff;
   logic                        csr_write;
   logic [fvnh_pkg::CSR_IDX_W-1:0] csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[fvnh_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= fvnh_pkg::RESET_SEED;
         octaves_ff <= fvnh_pkg::RESET_OCTAVES;
         freq_ff    <= fvnh_pkg::RESET_FREQUENCY;
         res_ff     <= fvnh_pkg::RESET_RESOLUTION;
      end else if (csr_write) begin
         unique case (csr_index)
            fvnh_pkg::REG_SEED:       seed_ff    <= pwdata;
            fvnh_pkg::REG_OCTAVES:    octaves_ff <= pwdata[fvnh_pkg::OCT_W-1:0];
            fvnh_pkg::REG_FREQUENCY:  freq_ff    <= pwdata[fvnh_pkg::FREQ_W-1:0];
            fvnh_pkg::REG_RESOLUTION: res_ff     <= pwdata[fvnh_pkg::RES_W-1:0];
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (csr_index)
         fvnh_pkg::REG_SEED:       prdata = seed_ff;
         fvnh_pkg::REG_OCTAVES:    prdata = fvnh_pkg::CSR_DATA_W'(octaves_ff);
         fvnh_pkg::REG_FREQUENCY:  prdata = fvnh_pkg::CSR_DATA_W'(freq_ff);
         fvnh_pkg::REG_RESOLUTION: prdata = fvnh_pkg::CSR_DATA_W'(res_ff);
      endcase
   end

   // clamp grid size and octave count
   logic [NW-1:0] n_eff;
   logic [KW-1:0] k_eff;
   logic [MAX_OCTAVES-1:0] amp_total;

   always_comb begin
      if (32'(res_ff) < 32'd2) begin
         n_eff = NW'(2);
      end else if (32'(res_ff) > 32'(MAX_RESOLUTION)) begin
         n_eff = NW'(MAX_RESOLUTION);
      end else begin
         n_eff = NW'(res_ff);
      end
      if (octaves_ff == '0) begin
         k_eff = KW'(1);
      end else if (32'(octaves_ff) > 32'(MAX_OCTAVES)) begin
         k_eff = KW'(MAX_OCTAVES);
      end else begin
         k_eff = KW'(octaves_ff);
      end
      amp_total = MAX_OCTAVES'((32'd1 << k_eff) - 32'd1);
   end

   // whole pipeline moves together
   logic advance;
   logic rsp_valid_ff;
   logic [fvnh_pkg::HEIGHT_W-1:0] height_ff;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // -------------------------------------------------------------------------
   // stage 1: scaled coordinates and border distance
   // -------------------------------------------------------------------------
   logic                 s1_valid_ff;
   logic [2:0][DW-1:0]   s1_num_ff;
   logic                 s1_outside_ff;
   logic                 s1_full_ff;
   logic [2:0][DW-1:0]   s1_num_in;
   logic                 s1_outside_in;
   logic                 s1_full_in;

   always_comb begin
      logic [AW-1:0]   px;
      logic [AW-1:0]   pz;
      logic [MW-1:0]   xv;
      logic [MW-1:0]   zv;
      logic [MW-1:0]   nv;
      logic [MW-1:0]   mv;
      logic [MW+1:0]   m4;
      px = AW'(req_ch.cell_x) * AW'(freq_ff);
      pz = AW'(req_ch.cell_z) * AW'(freq_ff);
      xv = MW'(req_ch.cell_x);
      zv = MW'(req_ch.cell_z);
      nv = MW'(n_eff);
      mv = xv;
      if (zv < mv) mv = zv;
      if (nv - xv < mv) mv = nv - xv;
      if (nv - zv < mv) mv = nv - zv;
      m4 = {mv, 2'b00};
      s1_outside_in = (xv >= nv) || (zv >= nv);
      s1_full_in    = (m4 >= (MW+2)'(nv));
      s1_num_in[0]  = DW'(px + (px << 1)) << (MAX_OCTAVES + 7);
      s1_num_in[1]  = DW'(pz + (pz << 1)) << (MAX_OCTAVES + 7);
      s1_num_in[2]  = DW'(m4) << FW;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_num_ff     <= s1_num_in;
         s1_outside_ff <= s1_outside_in;
         s1_full_ff    <= s1_full_in;
      end
   end

   // -------------------------------------------------------------------------
   // coordinate and edge division by grid size
   // -------------------------------------------------------------------------
   logic               dv_valid;
   logic [2:0][DW-1:0] dv_quo;
   logic [1:0]         dv_side;

   fvnh_div_pipe #(
      .LANES  (3),
      .NUM_W  (DW),
      .DEN_W  (NW),
      .SIDE_W (2)
   ) u_coord_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s1_valid_ff),
      .num       (s1_num_ff),
      .den       (n_eff),
      .side_in   ({s1_outside_ff, s1_full_ff}),
      .out_valid (dv_valid),
      .quo       (dv_quo),
      .side_out  (dv_side)
   );

   // -------------------------------------------------------------------------
   // per-octave hash, smoothstep and blend (four stages)
   // -------------------------------------------------------------------------
   function automatic logic [FW-1:0] mix16(input logic [FW-1:0] p,
                                           input logic [FW-1:0] q,
                                           input logic [FW-1:0] w);
      logic [32:0] acc;
      acc = 33'(p) * 33'(fvnh_pkg::ONE_Q16 - 17'(w)) + 33'(q) * 33'(w);
      return acc[31:16];
   endfunction

   logic [4:0]          hv_valid_ff;
   fvnh_pkg::side_type  hs_side_ff [5];
   fvnh_pkg::side_type  h1_side_in;
   logic [FW-1:0]       val_ff [MAX_OCTAVES];

   assign h1_side_in = '{outside: dv_side[1], edge_full: dv_side[0],
                         edge_gain: dv_quo[2][FW-1:0]};

   // carry valid and side-band through the octave stages and the sum stage
   always_ff @(posedge clock) begin
      if (reset) begin
         hv_valid_ff <= '0;
      end else if (advance) begin
         hv_valid_ff <= {hv_valid_ff[3:0], dv_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hs_side_ff[0] <= h1_side_in;
         for (int s = 1; s < 5; s++) hs_side_ff[s] <= hs_side_ff[s-1];
      end
   end

   for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
      logic [WW-1:0]   wx;
      logic [WW-1:0]   wz;
      logic [HW-1:0]   seed_o;
      logic [HW-1:0]   base_in;
      logic [FW-1:0]   tx;
      logic [FW-1:0]   tz;
      logic [HW-1:0]   base_ff;
      logic [FW-1:0]   t2x_ff;
      logic [FW-1:0]   t2z_ff;
      logic [17:0]     sx_ff;
      logic [17:0]     sz_ff;
      logic [3:0][HW-1:0] prod_ff;
      logic [3:0][HW-1:0] prod_in;
      logic [FW-1:0]   ux_ff;
      logic [FW-1:0]   uz_ff;
      logic [FW-1:0]   ux_in;
      logic [FW-1:0]   uz_in;
      logic [FW-1:0]   uz2_ff;
      logic [FW-1:0]   mab_ff;
      logic [FW-1:0]   mcd_ff;

      // octave sample position: drop the surplus doubling bits
      assign wx      = WW'(dv_quo[0]) >> (MAX_OCTAVES - 1 - o);
      assign wz      = WW'(dv_quo[1]) >> (MAX_OCTAVES - 1 - o);
      assign tx      = wx[FW-1:0];
      assign tz      = wz[FW-1:0];
      assign seed_o  = seed_ff + fvnh_pkg::SEED_STEP * HW'(o);
      assign base_in = wx[FW +: HW] * fvnh_pkg::HASH_MUL_X
                     + wz[FW +: HW] * fvnh_pkg::HASH_MUL_Z
                     + seed_o * fvnh_pkg::HASH_MUL_SEED;

      // hash corner base, square of fraction
      always_ff @(posedge clock) begin
         if (advance) begin
            base_ff <= base_in;
            t2x_ff  <= 16'((32'(tx) * 32'(tx)) >> 16);
            t2z_ff  <= 16'((32'(tz) * 32'(tz)) >> 16);
            sx_ff   <= fvnh_pkg::SMOOTH_THREE - {1'b0, tx, 1'b0};
            sz_ff   <= fvnh_pkg::SMOOTH_THREE - {1'b0, tz, 1'b0};
         end
      end

      // finish the four corner hashes and the smoothstep weights
      always_comb begin
         logic [3:0][HW-1:0] corner;
         logic [33:0]        smx;
         logic [33:0]        smz;
         corner[0] = base_ff;
         corner[1] = base_ff + fvnh_pkg::HASH_MUL_X;
         corner[2] = base_ff + fvnh_pkg::HASH_MUL_Z;
         corner[3] = base_ff + fvnh_pkg::HASH_MUL_X + fvnh_pkg::HASH_MUL_Z;
         for (int c = 0; c < 4; c++) begin
            prod_in[c] = (corner[c] ^ (corner[c] >> 13)) * fvnh_pkg::HASH_MUL_MIX;
         end
         smx   = 34'(t2x_ff) * 34'(sx_ff);
         smz   = 34'(t2z_ff) * 34'(sz_ff);
         ux_in = (smx[33:32] != 2'b00) ? '1 : smx[31:16];
         uz_in = (smz[33:32] != 2'b00) ? '1 : smz[31:16];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            prod_ff <= prod_in;
            ux_ff   <= ux_in;
            uz_ff   <= uz_in;
         end
      end

      // blend along x, then along z; corner value is the hash top half
      always_ff @(posedge clock) begin
         if (advance) begin
            mab_ff   <= mix16(prod_ff[0][31:16], prod_ff[1][31:16], ux_ff);
            mcd_ff   <= mix16(prod_ff[2][31:16], prod_ff[3][31:16], ux_ff);
            uz2_ff   <= uz_ff;
            val_ff[o] <= mix16(mab_ff, mcd_ff, uz2_ff);
         end
      end
   end

   // -------------------------------------------------------------------------
   // weighted octave sum
   // -------------------------------------------------------------------------
   logic [SW-1:0] sum_ff;
   logic [SW-1:0] sum_in;

   always_comb begin
      sum_in = '0;
      for (int o = 0; o < MAX_OCTAVES; o++) begin
         if (KW'(o) < k_eff) begin
            sum_in = sum_in + (SW'(val_ff[o]) << (k_eff - KW'(o) - KW'(1)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff <= sum_in;
      end
   end

   // normalise by the total amplitude
   logic                nd_valid;
   logic [0:0][SW-1:0]  nd_quo;
   logic [SIDE_W-1:0]   nd_side_vec;
   fvnh_pkg::side_type  nd_side;

   fvnh_div_pipe #(
      .LANES  (1),
      .NUM_W  (SW),
      .DEN_W  (MAX_OCTAVES),
      .SIDE_W (SIDE_W)
   ) u_norm_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (hv_valid_ff[4]),
      .num       (sum_ff),
      .den       (amp_total),
      .side_in   (hs_side_ff[4]),
      .out_valid (nd_valid),
      .quo       (nd_quo),
      .side_out  (nd_side_vec)
   );

   assign nd_side = nd_side_vec;

   // -------------------------------------------------------------------------
   // border falloff and response register
   // -------------------------------------------------------------------------
   logic [fvnh_pkg::HEIGHT_W-1:0] height_in;

   always_comb begin
      logic [31:0] scaled;
      scaled = 32'(nd_quo[0][FW-1:0]) * 32'(nd_side.edge_gain);
      if (nd_side.outside) begin
         height_in = '0;
      end else if (nd_side.edge_full) begin
         height_in = nd_quo[0][FW-1:0];
      end else begin
         height_in = scaled[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= nd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         height_ff <= height_in;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.height = height_ff;

`ifndef SYNTH
   // cells off the grid come back flat
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && nd_valid && nd_side.outside) |=> (rsp_ch.height == '0))
      else $error("off-grid cell gave non-zero height");

   // normalised noise never exceeds the Q0.16 range
   a_noise_range: assert property (@(posedge clock) disable iff (reset)
      nd_valid |-> (nd_quo[0][SW-1:FW] == '0))
      else $error("octave sum normalisation overflowed");

   // a stall freezes the pipeline occupancy
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(s1_valid_ff) && $stable(hv_valid_ff)))
      else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire
